// ----- hdl/rvx_pkg.sv -----
// Shared types, opcodes and decode helpers for the RV32I execute block.
`default_nettype none

package rvx_pkg;

  localparam int NUM_REGS_DEF   = 32;
  localparam int DMEM_WORDS_DEF = 4096;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_EXEC = 2'd0;
  localparam logic [1:0] CMD_WREG = 2'd1;
  localparam logic [1:0] CMD_RREG = 2'd2;

  // Fault codes
  localparam logic [1:0] FLT_NONE     = 2'd0;
  localparam logic [1:0] FLT_ILLEGAL  = 2'd1;
  localparam logic [1:0] FLT_MISALIGN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESET_PC  = 2'd0;
  localparam logic [1:0] CFG_STACK_TOP = 2'd1;
  localparam logic [1:0] CFG_PROG_WORDS = 2'd2;
  localparam logic [1:0] CFG_DATA_BASE = 2'd3;

  localparam logic [4:0] SP_REG = 5'd2;

  // Major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6f;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic [2:0] {
    CLS_ALU,
    CLS_LOAD,
    CLS_STORE,
    CLS_BRANCH,
    CLS_JAL,
    CLS_ILLEGAL
  } cls_t;

  // One queued transaction with its instruction class
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instr;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    cls_t        cls;
  } item_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic ready;
    logic busy;
  } back_stat_t;

  function automatic cls_t classify(input logic [6:0] op);
    cls_t c;
    unique case (op)
      OP_REG, OP_IMM: c = CLS_ALU;
      OP_LOAD:        c = CLS_LOAD;
      OP_STORE:       c = CLS_STORE;
      OP_BRANCH:      c = CLS_BRANCH;
      OP_JAL:         c = CLS_JAL;
      default:        c = CLS_ILLEGAL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rvx_if.sv -----
// Valid/ready channel interfaces for input commands and step results.
`default_nettype none

interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] instr;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  modport source(output valid, command, instr, reg_index, reg_value, input ready);
  modport sink(input valid, command, instr, reg_index, reg_value, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        halted;
  logic [1:0]  fault;
  logic        rd_written;
  logic [4:0]  rd_number;
  logic [31:0] rd_data;
  logic [31:0] read_data;
  logic [20:0] retired;
  modport source(output valid, next_pc, halted, fault, rd_written, rd_number, rd_data,
                 read_data, retired, input ready);
  modport sink(input valid, next_pc, halted, fault, rd_written, rd_number, rd_data,
               read_data, retired, output ready);
endinterface

`default_nettype wire

// ----- hdl/rv32i_integer_execute.sv -----
// Top level of the RV32I execute block: front queue, back end, checks.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        command, instr, reg_index, reg_value
//  out_ch   out  valid/ready        next_pc, halted, fault, rd_*, read_data, retired
//  cfg      in   cfg_we (no wait)   cfg_index, cfg_data
//
// One transaction a cycle while the output is not stalled; a load holds the back end
// in its ld_wait state because the data memory read is registered.
// After reset a clearing pass sweeps every data memory word while in_ch.ready stays
// low. A stalled output holds its result while the two-entry queue keeps accepting
// until it is full.
`default_nettype none

module rv32i_integer_execute #(
  parameter int NUM_REGS   = rvx_pkg::NUM_REGS_DEF,
  parameter int DMEM_WORDS = rvx_pkg::DMEM_WORDS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  rvx_in_if.sink     in_ch,
  rvx_out_if.source  out_ch,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [31:0] cfg_data
);

  logic                q_valid;
  rvx_pkg::item_t      q_item;
  rvx_pkg::back_stat_t stat;

  rvx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .stat    (stat)
  );

  rvx_back #(
    .NUM_REGS   (NUM_REGS),
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (stat),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // No transaction enters while memory is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_ch.ready) else $error("input accepted during clear");

  // A fault always comes with the halt flag
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.fault != rvx_pkg::FLT_NONE |-> out_ch.halted)
    else $error("fault without halt");

  // A fault, once reported, stays in later results
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(out_ch.valid && out_ch.ready && out_ch.fault != rvx_pkg::FLT_NONE) &&
    out_ch.valid |-> out_ch.fault != rvx_pkg::FLT_NONE)
    else $error("fault code cleared");

  // No register number or data without a write
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.rd_written |-> out_ch.rd_number == 5'd0 &&
    out_ch.rd_data == 32'd0) else $error("stray write report");

endmodule

`default_nettype wire

// ----- hdl/rvx_front.sv -----
// Front end: accept transactions, classify the instruction, queue two deep.
`default_nettype none

module rvx_front (
  input  wire               clk,
  input  wire               rst,
  rvx_in_if.sink            in_ch,
  output logic              q_valid,
  output rvx_pkg::item_t    q_item,
  input  rvx_pkg::back_stat_t stat
);

  rvx_pkg::item_t entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ch.ready = (count != 2'd2) && !stat.busy;
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && stat.ready;
  assign q_item  = entries[rp];

  // Store the classified transaction
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp].command   <= in_ch.command;
      entries[wp].instr     <= in_ch.instr;
      entries[wp].reg_index <= in_ch.reg_index;
      entries[wp].reg_value <= in_ch.reg_value;
      entries[wp].cls       <= rvx_pkg::classify(in_ch.instr[6:0]);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rvx_back.sv -----
// Back end: register read, execute, data memory and result register.
`default_nettype none

module rvx_back #(
  parameter int NUM_REGS   = rvx_pkg::NUM_REGS_DEF,
  parameter int DMEM_WORDS = rvx_pkg::DMEM_WORDS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  rvx_pkg::item_t      q_item,
  output rvx_pkg::back_stat_t stat,
  rvx_out_if.source           out_ch,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(DMEM_WORDS);
  localparam logic [31:0] WIN_BYTES = 32'(DMEM_WORDS * 4);
  localparam logic [AW-1:0] CLR_LAST = AW'(DMEM_WORDS - 1);

  // Architectural state
  logic [31:0] rf [NUM_REGS];
  logic [31:0] pc;
  logic [20:0] retire;
  logic        halt;
  logic [1:0]  fault;
  logic [20:0] prog_words;
  logic [31:0] data_base;

  // Data memory and clearing pass
  logic [31:0]   dmem [DMEM_WORDS];
  logic [31:0]   dmem_q;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Execute stage registers
  logic           r_v;
  rvx_pkg::item_t r_item;
  logic [31:0]    a;
  logic [31:0]    b;
  logic           ld_wait;

  // Output register
  logic out_v;
  logic out_free;

  logic          e_done;
  logic          need_wait;
  logic          take;
  logic [RW-1:0] ra1;
  logic [RW-1:0] ra2;

  logic          rf_we;
  logic [4:0]    rf_wn;
  logic [31:0]   rf_wd;

  // Decode fields
  logic [31:0] ins;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] addr;
  logic [31:0] addr_al;
  logic [31:0] off;
  logic        in_win;
  logic [AW-1:0] slot;

  // Execute results
  logic [1:0]  flt;
  logic        wr_res;
  logic [31:0] res;
  logic [31:0] npc;
  logic [31:0] opb;
  logic [4:0]  sh;
  logic [31:0] ld_word;
  logic [3:0]  st_be;
  logic [31:0] st_data;
  logic        st_we;
  logic        taken;

  // Next state
  logic [31:0] pc_next;
  logic [20:0] retire_next;
  logic        halt_next;
  logic [1:0]  fault_next;
  logic [31:0] rdata;
  logic        do_exec;

  assign need_wait = (r_item.command == rvx_pkg::CMD_EXEC) && (r_item.cls == rvx_pkg::CLS_LOAD);
  assign out_free  = !out_v || out_ch.ready;
  assign e_done    = r_v && out_free && (!need_wait || ld_wait);
  assign stat.ready = !r_v || e_done;
  assign stat.busy  = clearing;
  assign take       = q_valid && stat.ready;

  assign ra1 = (q_item.command == rvx_pkg::CMD_EXEC) ? RW'(q_item.instr[19:15])
                                                     : RW'(q_item.reg_index);
  assign ra2 = RW'(q_item.instr[24:20]);

  // Load operands, forwarding a result committed on the same edge
  always_ff @(posedge clk) begin
    if (take) begin
      r_item <= q_item;
      a <= (rf_we && RW'(rf_wn) == ra1) ? rf_wd : rf[ra1];
      b <= (rf_we && RW'(rf_wn) == ra2) ? rf_wd : rf[ra2];
    end
  end

  // Track the stage and the load wait cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      r_v     <= 1'b0;
      ld_wait <= 1'b0;
    end else begin
      if (stat.ready) r_v <= q_valid;
      if (e_done) ld_wait <= 1'b0;
      else if (r_v && need_wait) ld_wait <= 1'b1;
    end
  end

  // Decode
  assign ins   = r_item.instr;
  assign op    = ins[6:0];
  assign rd    = ins[11:7];
  assign f3    = ins[14:12];
  assign f7    = ins[31:25];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign addr    = a + ((r_item.cls == rvx_pkg::CLS_STORE) ? imm_s : imm_i);
  assign addr_al = {addr[31:2], 2'b00};
  assign off     = addr_al - data_base;
  assign in_win  = off < WIN_BYTES;
  assign slot    = off[AW+1:2];

  // Execute the instruction
  always_comb begin
    flt     = rvx_pkg::FLT_NONE;
    wr_res  = 1'b0;
    res     = '0;
    npc     = pc + 32'd4;
    opb     = (op == rvx_pkg::OP_REG) ? b : imm_i;
    sh      = opb[4:0];
    ld_word = (in_win ? dmem_q : 32'd0) >> {addr[1:0], 3'b000};
    st_be   = 4'b0000;
    st_data = b << {addr[1:0], 3'b000};
    taken   = 1'b0;
    case (r_item.cls)
      rvx_pkg::CLS_ALU: begin
        if (op == rvx_pkg::OP_REG) begin
          if (!(f7 == rvx_pkg::F7_BASE || (f7 == rvx_pkg::F7_ALT &&
                (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR))))
            flt = rvx_pkg::FLT_ILLEGAL;
        end else begin
          if ((f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) ||
              (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE && f7 != rvx_pkg::F7_ALT))
            flt = rvx_pkg::FLT_ILLEGAL;
        end
        case (f3)
          rvx_pkg::F3_ADD:  res = (op == rvx_pkg::OP_REG && f7 == rvx_pkg::F7_ALT) ?
                                  a - opb : a + opb;
          rvx_pkg::F3_SLL:  res = a << sh;
          rvx_pkg::F3_SLT:  res = {31'd0, $signed(a) < $signed(opb)};
          rvx_pkg::F3_SLTU: res = {31'd0, a < opb};
          rvx_pkg::F3_XOR:  res = a ^ opb;
          rvx_pkg::F3_SR:   res = (f7 == rvx_pkg::F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
          rvx_pkg::F3_OR:   res = a | opb;
          default:          res = a & opb;
        endcase
        wr_res = 1'b1;
      end
      rvx_pkg::CLS_LOAD: begin
        if (f3 == rvx_pkg::F3_SLTU || f3 > rvx_pkg::F3_LHU) flt = rvx_pkg::FLT_ILLEGAL;
        else if ((f3[1:0] == 2'd1 && addr[0]) || (f3 == rvx_pkg::F3_LW && addr[1:0] != 2'd0))
          flt = rvx_pkg::FLT_MISALIGN;
        case (f3)
          rvx_pkg::F3_LB:  res = {{24{ld_word[7]}}, ld_word[7:0]};
          rvx_pkg::F3_LH:  res = {{16{ld_word[15]}}, ld_word[15:0]};
          rvx_pkg::F3_LBU: res = {24'd0, ld_word[7:0]};
          rvx_pkg::F3_LHU: res = {16'd0, ld_word[15:0]};
          default:         res = ld_word;
        endcase
        wr_res = 1'b1;
      end
      rvx_pkg::CLS_STORE: begin
        if (f3 > rvx_pkg::F3_SW) flt = rvx_pkg::FLT_ILLEGAL;
        else if ((f3 == rvx_pkg::F3_SH && addr[0]) ||
                 (f3 == rvx_pkg::F3_SW && addr[1:0] != 2'd0))
          flt = rvx_pkg::FLT_MISALIGN;
        case (f3)
          rvx_pkg::F3_SB: st_be = 4'b0001 << addr[1:0];
          rvx_pkg::F3_SH: st_be = 4'b0011 << addr[1:0];
          default:        st_be = 4'b1111;
        endcase
      end
      rvx_pkg::CLS_BRANCH: begin
        case (f3)
          rvx_pkg::F3_BEQ:  taken = (a == b);
          rvx_pkg::F3_BNE:  taken = (a != b);
          rvx_pkg::F3_BLT:  taken = $signed(a) < $signed(b);
          rvx_pkg::F3_BGE:  taken = $signed(a) >= $signed(b);
          rvx_pkg::F3_BLTU: taken = a < b;
          rvx_pkg::F3_BGEU: taken = a >= b;
          default:          flt = rvx_pkg::FLT_ILLEGAL;
        endcase
        if (flt == rvx_pkg::FLT_NONE && taken) begin
          npc = pc + imm_b;
          if (npc[1:0] != 2'd0) flt = rvx_pkg::FLT_MISALIGN;
        end
      end
      rvx_pkg::CLS_JAL: begin
        npc = pc + imm_j;
        if (npc[1:0] != 2'd0) flt = rvx_pkg::FLT_MISALIGN;
        res    = pc + 32'd4;
        wr_res = 1'b1;
      end
      default: flt = rvx_pkg::FLT_ILLEGAL;
    endcase
  end

  // Work out the step's effect on state
  always_comb begin
    pc_next     = pc;
    retire_next = retire;
    halt_next   = halt;
    fault_next  = fault;
    rf_we       = 1'b0;
    rf_wn       = 5'd0;
    rf_wd       = 32'd0;
    rdata       = 32'd0;
    do_exec     = 1'b0;
    case (r_item.command)
      rvx_pkg::CMD_WREG: begin
        if (r_item.reg_index != 5'd0) begin
          rf_we = e_done;
          rf_wn = r_item.reg_index;
          rf_wd = r_item.reg_value;
        end
      end
      rvx_pkg::CMD_RREG: rdata = a;
      rvx_pkg::CMD_EXEC: begin
        if (!halt && retire >= prog_words) halt_next = 1'b1;
        do_exec = !halt && !(retire >= prog_words);
        if (do_exec) begin
          if (flt != rvx_pkg::FLT_NONE) begin
            fault_next = flt;
            halt_next  = 1'b1;
          end else begin
            if (wr_res && rd != 5'd0) begin
              rf_we = e_done;
              rf_wn = rd;
              rf_wd = res;
            end
            pc_next     = npc;
            retire_next = retire + 21'd1;
            if (retire_next >= prog_words) halt_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign st_we = e_done && do_exec && r_item.cls == rvx_pkg::CLS_STORE &&
                 flt == rvx_pkg::FLT_NONE && in_win;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) rf[i] <= 32'd0;
    end else begin
      if (rf_we) rf[RW'(rf_wn)] <= rf_wd;
      if (cfg_we && cfg_index == rvx_pkg::CFG_STACK_TOP && retire == 21'd0)
        rf[RW'(rvx_pkg::SP_REG)] <= cfg_data;
    end
  end

  // Data memory: clear, byte-lane store, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_addr] <= 32'd0;
    end else if (st_we) begin
      for (int i = 0; i < 4; i++)
        if (st_be[i]) dmem[slot][8*i +: 8] <= st_data[8*i +: 8];
    end
    dmem_q <= dmem[slot];
  end

  // Sweep the data memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == CLR_LAST) clearing <= 1'b0;
    end
  end

  // Commit state and take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= 32'd0;
      retire     <= 21'd0;
      halt       <= 1'b0;
      fault      <= rvx_pkg::FLT_NONE;
      prog_words <= 21'd1;
      data_base  <= 32'd0;
    end else begin
      if (e_done) begin
        pc     <= pc_next;
        retire <= retire_next;
        halt   <= halt_next;
        fault  <= fault_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          rvx_pkg::CFG_RESET_PC:   if (retire == 21'd0) pc <= cfg_data;
          rvx_pkg::CFG_PROG_WORDS: prog_words <= cfg_data[20:0];
          rvx_pkg::CFG_DATA_BASE:  data_base <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (out_free) out_v <= e_done;
  end

  always_ff @(posedge clk) begin
    if (e_done) begin
      out_ch.next_pc    <= pc_next;
      out_ch.halted     <= halt_next;
      out_ch.fault      <= fault_next;
      out_ch.rd_written <= rf_we;
      out_ch.rd_number  <= rf_wn;
      out_ch.rd_data    <= rf_wd;
      out_ch.read_data  <= rdata;
      out_ch.retired    <= retire_next;
    end
  end

  assign out_ch.valid = out_v;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the RV32I execute block with an in-line predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int MEM_WORDS = rvx_pkg::DMEM_WORDS_DEF;
  localparam int MAW = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);

  // Command code with no effect on the block
  localparam logic [1:0] CMD_IDLE = 2'd3;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [1:0]  fault;
    logic        rd_written;
    logic [4:0]  rd_number;
    logic [31:0] rd_data;
    logic [31:0] read_data;
    logic [20:0] retired;
  } step_res_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instr;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } cmd_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rvx_in_if  in_ch();
  rvx_out_if out_ch();

  rv32i_integer_execute dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted architectural state
  logic [31:0] regs_m [32];
  logic [31:0] mem_m [MEM_WORDS];
  logic [31:0] pc_m;
  logic [20:0] retired_m;
  logic [20:0] words_m;
  logic [31:0] base_m;
  logic        stop_m;
  logic [1:0]  fault_m;

  step_res_t pending_results[$];
  int mismatches = 0;
  bit calm = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = rvx_pkg::CMD_EXEC;
    in_ch.instr = '0;
    in_ch.reg_index = '0;
    in_ch.reg_value = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 32; i++) regs_m[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_m[i] = '0;
    pc_m = '0;
    retired_m = '0;
    words_m = 21'd1;
    base_m = '0;
    stop_m = 1'b0;
    fault_m = rvx_pkg::FLT_NONE;
  end

  // Compute the result of one transaction and advance the predicted state
  function automatic step_res_t predict_step(cmd_item_t it);
    step_res_t r;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, opnd, res, addr, npc, t, imm, lanes, wdat, off;
    logic [1:0] flt;
    logic wr, taken;
    r = '0;
    if (it.command == rvx_pkg::CMD_WREG) begin
      if (it.reg_index != 5'd0) begin
        regs_m[it.reg_index] = it.reg_value;
        r.rd_written = 1'b1;
        r.rd_number = it.reg_index;
        r.rd_data = it.reg_value;
      end
    end else if (it.command == rvx_pkg::CMD_RREG) begin
      r.read_data = regs_m[it.reg_index];
    end else if (it.command == rvx_pkg::CMD_EXEC) begin
      if (!stop_m && retired_m >= words_m) stop_m = 1'b1;
      if (!stop_m) begin
        op = it.instr[6:0];
        rd = it.instr[11:7];
        f3 = it.instr[14:12];
        f7 = it.instr[31:25];
        a = regs_m[it.instr[19:15]];
        b = regs_m[it.instr[24:20]];
        flt = rvx_pkg::FLT_NONE;
        wr = 1'b0;
        taken = 1'b0;
        res = '0;
        npc = pc_m + 32'd4;
        case (op)
          rvx_pkg::OP_REG, rvx_pkg::OP_IMM: begin
            if (op == rvx_pkg::OP_REG) begin
              if (!(f7 == rvx_pkg::F7_BASE || (f7 == rvx_pkg::F7_ALT &&
                    (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR))))
                flt = rvx_pkg::FLT_ILLEGAL;
              opnd = b;
            end else begin
              opnd = {{20{it.instr[31]}}, it.instr[31:20]};
              if ((f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) ||
                  (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE &&
                   f7 != rvx_pkg::F7_ALT))
                flt = rvx_pkg::FLT_ILLEGAL;
            end
            case (f3)
              rvx_pkg::F3_ADD:  res = (op == rvx_pkg::OP_REG && f7 == rvx_pkg::F7_ALT) ?
                                      a - opnd : a + opnd;
              rvx_pkg::F3_SLL:  res = a << opnd[4:0];
              rvx_pkg::F3_SLT:  res = {31'd0, $signed(a) < $signed(opnd)};
              rvx_pkg::F3_SLTU: res = {31'd0, a < opnd};
              rvx_pkg::F3_XOR:  res = a ^ opnd;
              rvx_pkg::F3_SR: begin
                if (f7 == rvx_pkg::F7_ALT) res = $signed(a) >>> opnd[4:0];
                else res = a >> opnd[4:0];
              end
              rvx_pkg::F3_OR:   res = a | opnd;
              default:          res = a & opnd;
            endcase
            wr = 1'b1;
          end
          rvx_pkg::OP_LOAD: begin
            addr = a + {{20{it.instr[31]}}, it.instr[31:20]};
            if (f3 == rvx_pkg::F3_SLTU || f3 > rvx_pkg::F3_LHU) flt = rvx_pkg::FLT_ILLEGAL;
            else if ((f3[1:0] == 2'd1 && addr[0]) ||
                     (f3 == rvx_pkg::F3_LW && addr[1:0] != 2'd0))
              flt = rvx_pkg::FLT_MISALIGN;
            else begin
              off = {addr[31:2], 2'b00} - base_m;
              t = (off < MEM_BYTES) ? mem_m[off[MAW+1:2]] : 32'd0;
              t = t >> {addr[1:0], 3'b000};
              case (f3)
                rvx_pkg::F3_LB:  res = {{24{t[7]}}, t[7:0]};
                rvx_pkg::F3_LH:  res = {{16{t[15]}}, t[15:0]};
                rvx_pkg::F3_LW:  res = t;
                rvx_pkg::F3_LBU: res = {24'd0, t[7:0]};
                default:         res = {16'd0, t[15:0]};
              endcase
              wr = 1'b1;
            end
          end
          rvx_pkg::OP_STORE: begin
            addr = a + {{20{it.instr[31]}}, it.instr[31:25], it.instr[11:7]};
            if (f3 > rvx_pkg::F3_SW) flt = rvx_pkg::FLT_ILLEGAL;
            else if ((f3 == rvx_pkg::F3_SH && addr[0]) ||
                     (f3 == rvx_pkg::F3_SW && addr[1:0] != 2'd0))
              flt = rvx_pkg::FLT_MISALIGN;
            else begin
              if (f3 == rvx_pkg::F3_SB) lanes = 32'hFF << {addr[1:0], 3'b000};
              else if (f3 == rvx_pkg::F3_SH) lanes = 32'hFFFF << {addr[1:0], 3'b000};
              else lanes = 32'hFFFF_FFFF;
              wdat = b << {addr[1:0], 3'b000};
              off = {addr[31:2], 2'b00} - base_m;
              if (off < MEM_BYTES)
                mem_m[off[MAW+1:2]] = (mem_m[off[MAW+1:2]] & ~lanes) | (wdat & lanes);
            end
          end
          rvx_pkg::OP_BRANCH: begin
            imm = {{19{it.instr[31]}}, it.instr[31], it.instr[7], it.instr[30:25],
                   it.instr[11:8], 1'b0};
            case (f3)
              rvx_pkg::F3_BEQ:  taken = (a == b);
              rvx_pkg::F3_BNE:  taken = (a != b);
              rvx_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
              rvx_pkg::F3_BGE:  taken = ($signed(a) >= $signed(b));
              rvx_pkg::F3_BLTU: taken = (a < b);
              rvx_pkg::F3_BGEU: taken = (a >= b);
              default:          flt = rvx_pkg::FLT_ILLEGAL;
            endcase
            if (flt == rvx_pkg::FLT_NONE && taken) begin
              npc = pc_m + imm;
              if (npc[1:0] != 2'd0) flt = rvx_pkg::FLT_MISALIGN;
            end
          end
          rvx_pkg::OP_JAL: begin
            imm = {{11{it.instr[31]}}, it.instr[31], it.instr[19:12], it.instr[20],
                   it.instr[30:21], 1'b0};
            npc = pc_m + imm;
            if (npc[1:0] != 2'd0) flt = rvx_pkg::FLT_MISALIGN;
            else begin
              res = pc_m + 32'd4;
              wr = 1'b1;
            end
          end
          default: flt = rvx_pkg::FLT_ILLEGAL;
        endcase
        if (flt != rvx_pkg::FLT_NONE) begin
          fault_m = flt;
          stop_m = 1'b1;
        end else begin
          if (wr && rd != 5'd0) begin
            regs_m[rd] = res;
            r.rd_written = 1'b1;
            r.rd_number = rd;
            r.rd_data = res;
          end
          pc_m = npc;
          retired_m = retired_m + 21'd1;
          if (retired_m >= words_m) stop_m = 1'b1;
        end
      end
    end
    r.next_pc = pc_m;
    r.halted = stop_m;
    r.fault = fault_m;
    r.retired = retired_m;
    return r;
  endfunction

  // Instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OP_JAL};
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Send one transaction; predict its result once it is accepted
  task automatic send_item(cmd_item_t it);
    int gap;
    bit rdy;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.instr <= it.instr;
    in_ch.reg_index <= it.reg_index;
    in_ch.reg_value <= it.reg_value;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    pending_results.push_back(predict_step(it));
  endtask

  task automatic exec(logic [31:0] ins);
    send_item('{rvx_pkg::CMD_EXEC, ins, 5'd0, 32'd0});
  endtask

  task automatic set_reg(logic [4:0] idx, logic [31:0] val);
    send_item('{rvx_pkg::CMD_WREG, 32'd0, idx, val});
  endtask

  task automatic get_reg(logic [4:0] idx);
    send_item('{rvx_pkg::CMD_RREG, 32'd0, idx, 32'd0});
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      rvx_pkg::CFG_RESET_PC:   if (retired_m == 21'd0) pc_m = val;
      rvx_pkg::CFG_STACK_TOP:  if (retired_m == 21'd0) regs_m[rvx_pkg::SP_REG] = val;
      rvx_pkg::CFG_PROG_WORDS: words_m = val[20:0];
      default:                 base_m = val;
    endcase
  endtask

  // Random well-formed transaction with random content
  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int p;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [11:0] imm;
    logic [4:0] rs1, rd;
    logic [1:0] mask;
    logic [31:0] a;
    it = '{rvx_pkg::CMD_EXEC, $urandom, 5'($urandom), $urandom};
    p = $urandom_range(0, 99);
    f3 = 3'($urandom);
    rd = 5'($urandom_range(0, 30));
    rs1 = ($urandom_range(0, 4) != 0) ? 5'd31 : 5'($urandom);
    imm = 12'($urandom);
    a = regs_m[rs1];
    if (p < 20) begin
      f7 = ((f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR) && $urandom_range(0, 1)) ?
           rvx_pkg::F7_ALT : rvx_pkg::F7_BASE;
      it.instr = enc_r(f7, 5'($urandom), 5'($urandom), f3, rd);
    end else if (p < 40) begin
      if (f3 == rvx_pkg::F3_SLL) imm[11:5] = rvx_pkg::F7_BASE;
      if (f3 == rvx_pkg::F3_SR)
        imm[11:5] = $urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE;
      it.instr = enc_i(rvx_pkg::OP_IMM, imm, 5'($urandom), f3, rd);
    end else if (p < 55) begin
      case ($urandom_range(0, 4))
        0: f3 = rvx_pkg::F3_LB;
        1: f3 = rvx_pkg::F3_LH;
        2: f3 = rvx_pkg::F3_LW;
        3: f3 = rvx_pkg::F3_LBU;
        default: f3 = rvx_pkg::F3_LHU;
      endcase
      mask = (f3 == rvx_pkg::F3_LW) ? 2'd3 : (f3[1:0] == 2'd1) ? 2'd1 : 2'd0;
      imm[1:0] = (imm[1:0] & ~mask) | ((2'd0 - a[1:0]) & mask);
      it.instr = enc_i(rvx_pkg::OP_LOAD, imm, rs1, f3, rd);
    end else if (p < 70) begin
      f3 = 3'($urandom_range(0, 2));
      mask = (f3 == rvx_pkg::F3_SW) ? 2'd3 : (f3 == rvx_pkg::F3_SH) ? 2'd1 : 2'd0;
      imm[1:0] = (imm[1:0] & ~mask) | ((2'd0 - a[1:0]) & mask);
      it.instr = enc_s(imm, 5'($urandom), rs1, f3);
    end else if (p < 82) begin
      while (f3 == rvx_pkg::F3_SLT || f3 == rvx_pkg::F3_SLTU) f3 = 3'($urandom);
      it.instr = enc_b(13'($urandom) & 13'h1FFC, 5'($urandom), 5'($urandom), f3);
    end else if (p < 87) begin
      it.instr = enc_j(21'($urandom) & 21'h1FFFFC, rd);
    end else if (p < 93) begin
      it.command = rvx_pkg::CMD_WREG;
      if (it.reg_index == 5'd31) it.reg_value = base_m + $urandom_range(0, 16383);
    end else if (p < 98) begin
      it.command = rvx_pkg::CMD_RREG;
    end else begin
      it.command = CMD_IDLE;
    end
    return it;
  endfunction

  // Hold or release the result channel
  int stall = 0;
  always @(posedge clk) begin
    if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Sample the result channel away from the clock edge
  bit        mon_fire;
  step_res_t mon_res;
  always @(negedge clk) begin
    mon_fire = !rst && out_ch.valid && out_ch.ready;
    mon_res = '{out_ch.next_pc, out_ch.halted, out_ch.fault, out_ch.rd_written,
                out_ch.rd_number, out_ch.rd_data, out_ch.read_data, out_ch.retired};
  end

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h actual %h", field, want, got);
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    step_res_t want;
    if (mon_fire) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result next_pc", 32'd0, mon_res.next_pc);
      end else begin
        want = pending_results.pop_front();
        if (want.next_pc !== mon_res.next_pc)
          note_mismatch("next_pc", want.next_pc, mon_res.next_pc);
        if (want.halted !== mon_res.halted)
          note_mismatch("halted", want.halted, mon_res.halted);
        if (want.fault !== mon_res.fault)
          note_mismatch("fault", want.fault, mon_res.fault);
        if (want.rd_written !== mon_res.rd_written)
          note_mismatch("rd_written", want.rd_written, mon_res.rd_written);
        if (want.rd_number !== mon_res.rd_number)
          note_mismatch("rd_number", want.rd_number, mon_res.rd_number);
        if (want.rd_data !== mon_res.rd_data)
          note_mismatch("rd_data", want.rd_data, mon_res.rd_data);
        if (want.read_data !== mon_res.read_data)
          note_mismatch("read_data", want.read_data, mon_res.read_data);
        if (want.retired !== mon_res.retired)
          note_mismatch("retired", want.retired, mon_res.retired);
      end
    end
  end

  // Start values: extremes, then the working setup
  task automatic test_config_start();
    cfg_write(rvx_pkg::CFG_RESET_PC, 32'hFFFF_FFFF);
    cfg_write(rvx_pkg::CFG_STACK_TOP, 32'hFFFF_FFFF);
    get_reg(rvx_pkg::SP_REG);
    drain();
    cfg_write(rvx_pkg::CFG_RESET_PC, 32'h0);
    cfg_write(rvx_pkg::CFG_STACK_TOP, 32'h0);
    get_reg(rvx_pkg::SP_REG);
    drain();
    cfg_write(rvx_pkg::CFG_RESET_PC, 32'h0000_0100);
    cfg_write(rvx_pkg::CFG_STACK_TOP, 32'h2000_0000);
    cfg_write(rvx_pkg::CFG_PROG_WORDS, 32'h0010_0000);
    cfg_write(rvx_pkg::CFG_DATA_BASE, 32'h8000_0000);
    get_reg(rvx_pkg::SP_REG);
    drain();
  endtask

  task automatic test_directed();
    set_reg(5'd31, 32'h8000_0800);
    set_reg(5'd1, 32'h8000_0000);
    set_reg(5'd3, 32'h7FFF_FFFF);
    set_reg(5'd0, 32'hFFFF_FFFF);       // dropped
    get_reg(5'd0);
    send_item('{CMD_IDLE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF});
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_ADD, 5'd4));
    exec(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd1, rvx_pkg::F3_ADD, 5'd5));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd3, rvx_pkg::F3_SLL, 5'd6));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_SLT, 5'd7));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_SLTU, 5'd8));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_XOR, 5'd9));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_SR, 5'd10));
    exec(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd1, rvx_pkg::F3_SR, 5'd11));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_OR, 5'd12));
    exec(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_AND, 5'd13));
    exec(enc_i(rvx_pkg::OP_IMM, 12'h800, 5'd1, rvx_pkg::F3_ADD, 5'd0));  // x0 stays zero
    exec(enc_i(rvx_pkg::OP_IMM, 12'hFFF, 5'd3, rvx_pkg::F3_SLT, 5'd14));
    exec(enc_i(rvx_pkg::OP_IMM, 12'hFFF, 5'd3, rvx_pkg::F3_SLTU, 5'd15));
    exec(enc_i(rvx_pkg::OP_IMM, 12'h7FF, 5'd1, rvx_pkg::F3_XOR, 5'd16));
    exec(enc_i(rvx_pkg::OP_IMM, 12'h01F, 5'd3, rvx_pkg::F3_SLL, 5'd17));
    exec(enc_i(rvx_pkg::OP_IMM, {rvx_pkg::F7_ALT, 5'd31}, 5'd1, rvx_pkg::F3_SR, 5'd18));
    exec(enc_i(rvx_pkg::OP_IMM, 12'h004, 5'd1, rvx_pkg::F3_SR, 5'd19));
    exec(enc_s(12'h000, 5'd3, 5'd31, rvx_pkg::F3_SW));
    exec(enc_s(12'h001, 5'd1, 5'd31, rvx_pkg::F3_SB));
    exec(enc_s(12'h7FE, 5'd1, 5'd31, rvx_pkg::F3_SH));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h000, 5'd31, rvx_pkg::F3_LW, 5'd20));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h001, 5'd31, rvx_pkg::F3_LB, 5'd21));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h003, 5'd31, rvx_pkg::F3_LBU, 5'd22));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h7FE, 5'd31, rvx_pkg::F3_LH, 5'd23));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h7FE, 5'd31, rvx_pkg::F3_LHU, 5'd24));
    exec(enc_i(rvx_pkg::OP_LOAD, 12'h000, 5'd0, rvx_pkg::F3_LW, 5'd25));  // outside the window
    exec(enc_s(12'h800, 5'd3, 5'd0, rvx_pkg::F3_SW));                     // outside, ignored
    exec(enc_b(13'h0008, 5'd1, 5'd1, rvx_pkg::F3_BEQ));
    exec(enc_b(13'h0008, 5'd1, 5'd1, rvx_pkg::F3_BNE));
    exec(enc_b(13'h1FF8, 5'd3, 5'd1, rvx_pkg::F3_BLT));
    exec(enc_b(13'h0FFC, 5'd3, 5'd1, rvx_pkg::F3_BGE));
    exec(enc_b(13'h1000, 5'd1, 5'd3, rvx_pkg::F3_BLTU));
    exec(enc_b(13'h0010, 5'd1, 5'd3, rvx_pkg::F3_BGEU));
    exec(enc_j(21'h0FFFFC, 5'd26));
    exec(enc_j(21'h100000, 5'd27));
    get_reg(5'd27);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 1; i < 31; i++) set_reg(5'(i), $urandom);
    set_reg(5'd31, base_m + $urandom_range(2048, 14000));
    repeat (n) send_item(random_item());
    drain();
  endtask

  // Finish with a halt: illegal, misaligned or the program limit
  task automatic test_halt();
    cmd_item_t it;
    case ($urandom_range(0, 2))
      0: while (!stop_m) exec($urandom);
      1: begin
        set_reg(5'd31, base_m + 32'd101);
        if ($urandom_range(0, 1))
          exec(enc_i(rvx_pkg::OP_LOAD, 12'h000, 5'd31, rvx_pkg::F3_LW, 5'd1));
        else exec(enc_s(12'h000, 5'd1, 5'd31, rvx_pkg::F3_SH));
      end
      default: begin
        drain();
        if ($urandom_range(0, 1)) cfg_write(rvx_pkg::CFG_PROG_WORDS, {11'd0, retired_m});
        else cfg_write(rvx_pkg::CFG_PROG_WORDS, {11'd0, retired_m + 21'd4});
        while (!stop_m)
          exec(enc_i(rvx_pkg::OP_IMM, 12'($urandom), 5'd1, rvx_pkg::F3_ADD, 5'd1));
      end
    endcase
    // Nothing executes once halted; debug access still works
    repeat (12) begin
      it = '{2'($urandom), $urandom, 5'($urandom), $urandom};
      send_item(it);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_config_start();
    test_directed();
    test_random(100);
    cfg_write(rvx_pkg::CFG_DATA_BASE, 32'h0);
    cfg_write(rvx_pkg::CFG_STACK_TOP, 32'hFFFF_FFFF);   // no effect once retiring
    calm = 1'b1;
    test_random(40);
    calm = 1'b0;
    cfg_write(rvx_pkg::CFG_DATA_BASE, 32'hFFFF_C000);
    test_random(100);
    cfg_write(rvx_pkg::CFG_DATA_BASE, 32'h0000_1234);
    test_random(40);
    test_halt();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
